### rtl/core/m2a_pkg.sv
// Shared types, constants and helpers for the 2x2 matrix arithmetic unit.
`default_nettype none

package m2a_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int DQ_W      = PROD_W + 1 - FRAC_BITS;
    localparam int NUM_W     = WORD_W + FRAC_BITS;
    localparam int DIV_LAT   = NUM_W + 1;
    localparam int SAT_IN_W  = PROD_W + 2;
    localparam int Q_DEPTH   = 2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [DQ_W-1:0]   dq_t;
    typedef logic signed [WORD_W:0]   num_t;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_SCALE = 4'd3,
        OP_DIV   = 4'd4,
        OP_DET   = 4'd5,
        OP_INV   = 4'd6,
        OP_TRANS = 4'd7,
        OP_EQUAL = 4'd8,
        OP_NONE  = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_SINGULAR = 2'd2
    } status_t;

    typedef struct packed {
        op_t            op;
        word_t [3:0]    a;
        word_t [3:0]    b;
        word_t          scalar;
    } item_t;

    typedef struct packed {
        op_t            op;
        status_t        status;
        word_t [3:0]    r;
        word_t          det;
        logic           eq;
    } side_t;

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = SAT_IN_W'(64'sd2147483647);
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = SAT_IN_W'(-64'sd2147483648);

    function automatic word_t sat32(input logic signed [SAT_IN_W-1:0] v);
        word_t res;
        if (v > SAT_MAX)
        begin
            res = SAT_MAX[WORD_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            res = SAT_MIN[WORD_W-1:0];
        end
        else
        begin
            res = v[WORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/m2a_front.sv
// Front end: takes command transfers and classifies them for the queue.
`default_nettype none

module m2a_front (
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  logic [3:0]      command,
    input  m2a_pkg::word_t  a_00,
    input  m2a_pkg::word_t  a_01,
    input  m2a_pkg::word_t  a_10,
    input  m2a_pkg::word_t  a_11,
    input  m2a_pkg::word_t  b_00,
    input  m2a_pkg::word_t  b_01,
    input  m2a_pkg::word_t  b_10,
    input  m2a_pkg::word_t  b_11,
    input  m2a_pkg::word_t  scalar,
    input  logic            q_full,
    output logic            q_push,
    output m2a_pkg::item_t  q_item
);
    import m2a_pkg::*;

    op_t op;

    always_comb
    begin
        case (command)
            OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_DIV,
            OP_DET, OP_INV, OP_TRANS, OP_EQUAL: op = op_t'(command);
            default:                            op = OP_NONE;
        endcase
    end

    assign cmd_ready = !q_full;
    assign q_push    = cmd_valid && !q_full;

    always_comb
    begin
        q_item.op     = op;
        q_item.a[0]   = a_00;
        q_item.a[1]   = a_01;
        q_item.a[2]   = a_10;
        q_item.a[3]   = a_11;
        q_item.b[0]   = b_00;
        q_item.b[1]   = b_01;
        q_item.b[2]   = b_10;
        q_item.b[3]   = b_11;
        q_item.scalar = scalar;
    end

endmodule

`default_nettype wire

### rtl/core/m2a_queue.sv
// Short FIFO between front end and execution pipeline.
`default_nettype none

module m2a_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  m2a_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output m2a_pkg::item_t  head_item
);
    import m2a_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    item_t              mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/m2a_div.sv
// Pipelined signed restoring divider, one quotient bit per stage, saturated result.
`default_nettype none

module m2a_div (
    input  logic            clk,
    input  logic            en,
    input  m2a_pkg::num_t   num,
    input  m2a_pkg::dq_t    den,
    output m2a_pkg::word_t  quo
);
    import m2a_pkg::*;

    logic [NUM_W-1:0]   nq_reg  [NUM_W+1];
    logic [DQ_W-1:0]    den_reg [NUM_W+1];
    logic [DQ_W-1:0]    rem_reg [NUM_W+1];
    logic               neg_reg [NUM_W+1];

    num_t               num_abs;
    dq_t                den_abs;
    logic [NUM_W-1:0]   q_mag;
    logic signed [NUM_W:0] q_signed;

    assign num_abs = num[WORD_W] ? -num : num;
    assign den_abs = den[DQ_W-1] ? -den : den;

    // entry stage: magnitudes, dividend pre-shifted by the fraction width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0]  <= {num_abs[WORD_W-1:0], {FRAC_BITS{1'b0}}};
            den_reg[0] <= den_abs;
            rem_reg[0] <= '0;
            neg_reg[0] <= num[WORD_W] ^ den[DQ_W-1];
        end
    end

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [DQ_W:0] trial;
        logic [DQ_W:0] diff;
        logic          ge;

        assign trial = {rem_reg[k], nq_reg[k][NUM_W-1]};
        assign ge    = (trial >= {1'b0, den_reg[k]});
        assign diff  = trial - {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[DQ_W-1:0] : trial[DQ_W-1:0];
                nq_reg[k+1]  <= {nq_reg[k][NUM_W-2:0], ge};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign q_mag    = nq_reg[NUM_W];
    assign q_signed = neg_reg[NUM_W] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign quo      = sat32(SAT_IN_W'(q_signed));

endmodule

`default_nettype wire

### rtl/core/m2a_back.sv
// Execution pipeline: multipliers, determinant, four dividers and the result register.
`default_nettype none

module m2a_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  m2a_pkg::item_t  q_item,
    output logic            q_pop,
    output logic            res_valid,
    input  logic            res_ready,
    output m2a_pkg::word_t  r_00,
    output m2a_pkg::word_t  r_01,
    output m2a_pkg::word_t  r_10,
    output m2a_pkg::word_t  r_11,
    output m2a_pkg::word_t  det_value,
    output logic            equal_flag,
    output logic [1:0]      status
);
    import m2a_pkg::*;

    logic       en;

    // stage 1: products
    logic       s1_valid_reg;
    item_t      s1_item_reg;
    prod_t      s1_p_reg [4];
    prod_t      ma [4];
    prod_t      mb [4];

    // stage 2: rounded products and determinant
    logic       s2_valid_reg;
    item_t      s2_item_reg;
    word_t      s2_fl_reg [4];
    dq_t        s2_dq_reg;
    logic signed [PROD_W:0] det_diff;

    // stage 3 and divider alignment line
    side_t      side;
    num_t       div_num [4];
    dq_t        div_den;
    word_t      div_q [4];
    side_t      side_reg [DIV_LAT];
    logic       vld_reg  [DIV_LAT];

    // result register
    logic       res_valid_reg;
    side_t      res_reg, res_next;

    assign en    = !res_valid_reg || res_ready;
    assign q_pop = en && q_valid;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ma[i] = prod_t'($signed(q_item.a[i]));
            mb[i] = '0;
        end
        case (q_item.op)
            OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mb[i] = prod_t'($signed(q_item.b[i]));
                end
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mb[i] = prod_t'($signed(q_item.scalar));
                end
            end
            OP_DET, OP_INV:
            begin
                ma[0] = prod_t'($signed(q_item.a[0]));
                mb[0] = prod_t'($signed(q_item.a[3]));
                ma[1] = prod_t'($signed(q_item.a[1]));
                mb[1] = prod_t'($signed(q_item.a[2]));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= q_item;
            for (int i = 0; i < 4; i++)
            begin
                s1_p_reg[i] <= ma[i] * mb[i];
            end
        end
    end

    // exact floor of (p0 - p1) / 2^FRAC_BITS
    assign det_diff = (PROD_W+1)'(s1_p_reg[0]) - (PROD_W+1)'(s1_p_reg[1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_item_reg <= s1_item_reg;
            s2_dq_reg   <= DQ_W'(det_diff >>> FRAC_BITS);
            for (int i = 0; i < 4; i++)
            begin
                s2_fl_reg[i] <= sat32(SAT_IN_W'(s1_p_reg[i] >>> FRAC_BITS));
            end
        end
    end

    always_comb
    begin
        side.op     = s2_item_reg.op;
        side.status = ST_OK;
        side.r      = '0;
        side.det    = '0;
        side.eq     = 1'b0;
        div_den     = '0;
        for (int i = 0; i < 4; i++)
        begin
            div_num[i] = '0;
        end
        case (s2_item_reg.op)
            OP_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    side.r[i] = sat32(SAT_IN_W'($signed(s2_item_reg.a[i]))
                                    + SAT_IN_W'($signed(s2_item_reg.b[i])));
                end
            end
            OP_SUB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    side.r[i] = sat32(SAT_IN_W'($signed(s2_item_reg.a[i]))
                                    - SAT_IN_W'($signed(s2_item_reg.b[i])));
                end
            end
            OP_MUL, OP_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    side.r[i] = s2_fl_reg[i];
                end
            end
            OP_DIV:
            begin
                if (s2_item_reg.scalar == '0)
                begin
                    side.status = ST_DIVZERO;
                end
                for (int i = 0; i < 4; i++)
                begin
                    div_num[i] = num_t'($signed(s2_item_reg.a[i]));
                end
                div_den = dq_t'($signed(s2_item_reg.scalar));
            end
            OP_DET:
            begin
                side.det = sat32(SAT_IN_W'(s2_dq_reg));
            end
            OP_INV:
            begin
                if (s2_dq_reg == '0)
                begin
                    side.status = ST_SINGULAR;
                end
                div_num[0] = num_t'($signed(s2_item_reg.a[3]));
                div_num[1] = -num_t'($signed(s2_item_reg.a[1]));
                div_num[2] = -num_t'($signed(s2_item_reg.a[2]));
                div_num[3] = num_t'($signed(s2_item_reg.a[0]));
                div_den    = s2_dq_reg;
            end
            OP_TRANS:
            begin
                side.r[0] = s2_item_reg.a[0];
                side.r[1] = s2_item_reg.a[2];
                side.r[2] = s2_item_reg.a[1];
                side.r[3] = s2_item_reg.a[3];
            end
            OP_EQUAL:
            begin
                side.eq = (s2_item_reg.a == s2_item_reg.b);
            end
            default:
            begin
            end
        endcase
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        m2a_div u_div (
            .clk (clk),
            .en  (en),
            .num (div_num[i]),
            .den (div_den),
            .quo (div_q[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_comb
    begin
        res_next = side_reg[DIV_LAT-1];
        if ((res_next.op == OP_DIV || res_next.op == OP_INV) && res_next.status == ST_OK)
        begin
            for (int i = 0; i < 4; i++)
            begin
                res_next.r[i] = div_q[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            vld_reg[0]    <= s2_valid_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            res_valid_reg <= vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign r_00       = res_reg.r[0];
    assign r_01       = res_reg.r[1];
    assign r_10       = res_reg.r[2];
    assign r_11       = res_reg.r[3];
    assign det_value  = res_reg.det;
    assign equal_flag = res_reg.eq;
    assign status     = res_reg.status;

endmodule

`default_nettype wire

### rtl/core/matrix2x2_alu_core.sv
// Top level of the 2x2 signed fixed-point matrix arithmetic unit.
//
// Command channel (cmd_valid/cmd_ready): one transfer carries a command, matrices A and B
// and a scalar, all signed Q16.16. Result channel (res_valid/res_ready): exactly one
// transfer per command, in order, carrying the result matrix, det_value, equal_flag and
// status (0 ok, 1 division by zero, 2 singular matrix).
//
// Throughput: one command per cycle while the receiver keeps up.
// Path: every command passes the queue, the multiply and determinant stages, the divider
// alignment line and the result register. The depth is set by the restoring dividers, one
// quotient bit per stage over the FRAC_BITS-shifted 48-bit dividend.
// Every command travels the same path.
//
// Structure: a front end classifies commands into a two-entry queue; the execution
// pipeline pops from it and advances as a whole whenever the result register is empty
// or being taken. A stalled receiver holds the pipeline; the queue then fills and
// cmd_ready drops. No command is lost or duplicated.
//
// Reset (rst_n, asynchronous, active low) empties the queue and all pipeline stages.
`default_nettype none

module matrix2x2_alu_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  logic [3:0]      command,
    input  m2a_pkg::word_t  a_00,
    input  m2a_pkg::word_t  a_01,
    input  m2a_pkg::word_t  a_10,
    input  m2a_pkg::word_t  a_11,
    input  m2a_pkg::word_t  b_00,
    input  m2a_pkg::word_t  b_01,
    input  m2a_pkg::word_t  b_10,
    input  m2a_pkg::word_t  b_11,
    input  m2a_pkg::word_t  scalar,
    output logic            res_valid,
    input  logic            res_ready,
    output m2a_pkg::word_t  r_00,
    output m2a_pkg::word_t  r_01,
    output m2a_pkg::word_t  r_10,
    output m2a_pkg::word_t  r_11,
    output m2a_pkg::word_t  det_value,
    output logic            equal_flag,
    output logic [1:0]      status
);
    import m2a_pkg::*;

    // front end to queue
    logic   q_push;
    logic   q_full;
    item_t  push_item;

    // queue to execution pipeline
    logic   q_valid;
    logic   q_pop;
    item_t  head_item;

    m2a_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .command   (command),
        .a_00      (a_00),
        .a_01      (a_01),
        .a_10      (a_10),
        .a_11      (a_11),
        .b_00      (b_00),
        .b_01      (b_01),
        .b_10      (b_10),
        .b_11      (b_11),
        .scalar    (scalar),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    m2a_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    // execution: fixed-depth pipeline, stalls as one block on result back-pressure
    m2a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .r_00       (r_00),
        .r_01       (r_01),
        .r_10       (r_10),
        .r_11       (r_11),
        .det_value  (det_value),
        .equal_flag (equal_flag),
        .status     (status)
    );

endmodule

`default_nettype wire

### rtl/core/m2a_chk.sv
// Port-level checker for the matrix unit, bound to the top level.
`default_nettype none

module m2a_chk (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            res_valid,
    input  wire logic            res_ready,
    input  wire m2a_pkg::word_t  r_00,
    input  wire m2a_pkg::word_t  r_01,
    input  wire m2a_pkg::word_t  r_10,
    input  wire m2a_pkg::word_t  r_11,
    input  wire m2a_pkg::word_t  det_value,
    input  wire logic            equal_flag,
    input  wire logic [1:0]      status
);
    import m2a_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(r_00) && $stable(r_11) && $stable(status)
                                    && $stable(det_value))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status == ST_OK || status == ST_DIVZERO || status == ST_SINGULAR)
        else $error("bad status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_OK |-> r_00 == '0 && r_01 == '0 && r_10 == '0
                                         && r_11 == '0 && det_value == '0 && !equal_flag)
        else $error("error result not zero");

    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && equal_flag |-> det_value == '0 && r_00 == '0 && status == ST_OK)
        else $error("equal result carries other data");

endmodule

bind matrix2x2_alu_core m2a_chk u_m2a_chk (.*);

`default_nettype wire
